@@ sv/nearest_neighbor_scaler_defines.svh @@
// Assertion macros used by the checker file.
`ifndef NEAREST_NEIGHBOR_SCALER_DEFINES_SVH
`define NEAREST_NEIGHBOR_SCALER_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define NNS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nns assertion failed");

// Check that a condition implies another in the next cycle.
`define NNS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nns assertion failed");

`endif

@@ sv/nns_pkg.sv @@
`timescale 1ns / 1ps
package nns_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int COORD_W    = 8;
    localparam int DIM_W      = 9;
    localparam int PIX_W      = 32;
    localparam int ADDR_W     = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int NUM_W      = COORD_W + DIM_W;
    localparam int Q_W        = COORD_W;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    typedef enum logic [1:0] {
        REG_SRC_WIDTH  = 2'd0,
        REG_SRC_HEIGHT = 2'd1,
        REG_DST_WIDTH  = 2'd2,
        REG_DST_HEIGHT = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        ACT_LOAD  = 1'b0,
        ACT_FETCH = 1'b1
    } action_t;

    typedef struct packed {
        action_t              action;
        logic [COORD_W-1:0]   col;
        logic [COORD_W-1:0]   row;
        logic [PIX_W-1:0]     pixel_in;
    } in_item_t;

    typedef struct packed {
        logic [PIX_W-1:0]     pixel_out;
        logic                 error;
    } out_item_t;

    typedef struct packed {
        logic [DIM_W-1:0]     src_width;
        logic [DIM_W-1:0]     src_height;
        logic [DIM_W-1:0]     dst_width;
        logic [DIM_W-1:0]     dst_height;
    } cfg_t;

    // Classified operation passed from the front to the back
    typedef struct packed {
        logic                 fetch;
        logic                 err;
        logic [NUM_W-1:0]     num_x;
        logic [NUM_W-1:0]     num_y;
        logic [ADDR_W-1:0]    addr;
        logic [PIX_W-1:0]     pixel;
    } op_t;

    function automatic logic [ADDR_W-1:0] store_addr(
        input logic [COORD_W-1:0] row,
        input logic [COORD_W-1:0] col
    );
        return ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_WIDTH)) + ADDR_W'(col);
    endfunction

endpackage

@@ sv/nearest_neighbor_scaler.sv @@
`timescale 1ns / 1ps
// Nearest-neighbor scaler: load items write 32-bit source pixels into a 256x256
// store, fetch items map a destination (row, col) to the source pixel at
// col*src_width/dst_width, row*src_height/dst_height and return it; one result
// per item, with error set and a zero pixel when a dimension is zero or too
// large or a coordinate is out of range. One item per clock is sustained while
// the output is not stalled. An item passes from its input transfer through the
// queue into the first back-end stage, through the bit-per-stage divider pair,
// and through the store read into the output register. A four-entry queue
// between the input checks and the back end absorbs short output stalls; each
// back-end advance reads the store, and a valid load may also write it.
module nearest_neighbor_scaler
    import nns_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [DIM_W-1:0]    cfg_wdata,
    input  logic                in_valid,
    output logic                in_stall,
    input  in_item_t            in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output out_item_t           out_data
);

    cfg_t cfg;
    logic push;
    op_t  push_data;
    logic pop;
    op_t  head;
    logic empty;
    logic full;

    nns_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .in_stall  (in_stall),
        .full      (full),
        .push      (push),
        .push_data (push_data),
        .cfg       (cfg)
    );

    nns_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .empty     (empty),
        .full      (full)
    );

    nns_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

@@ sv/nns_front.sv @@
`timescale 1ns / 1ps
module nns_front
    import nns_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [DIM_W-1:0]    cfg_wdata,
    input  logic                in_valid,
    input  in_item_t            in_data,
    output logic                in_stall,
    input  logic                full,
    output logic                push,
    output op_t                 push_data,
    output cfg_t                cfg
);

    cfg_t cfg_reg;
    logic src_ok;
    logic dst_ok;
    logic load_err;
    logic fetch_err;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SRC_WIDTH:  cfg_reg.src_width  <= cfg_wdata;
                REG_SRC_HEIGHT: cfg_reg.src_height <= cfg_wdata;
                REG_DST_WIDTH:  cfg_reg.dst_width  <= cfg_wdata;
                REG_DST_HEIGHT: cfg_reg.dst_height <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

    // Classify the item: range checks and division numerators
    always_comb
    begin
        src_ok = (cfg_reg.src_width != '0) && (int'(cfg_reg.src_width) <= MAX_WIDTH) &&
                 (cfg_reg.src_height != '0) && (int'(cfg_reg.src_height) <= MAX_HEIGHT);
        dst_ok = (cfg_reg.dst_width != '0) && (int'(cfg_reg.dst_width) <= MAX_WIDTH) &&
                 (cfg_reg.dst_height != '0) && (int'(cfg_reg.dst_height) <= MAX_HEIGHT);
        load_err = !src_ok ||
                   ({1'b0, in_data.col} >= cfg_reg.src_width) ||
                   ({1'b0, in_data.row} >= cfg_reg.src_height);
        fetch_err = !src_ok || !dst_ok ||
                    ({1'b0, in_data.col} >= cfg_reg.dst_width) ||
                    ({1'b0, in_data.row} >= cfg_reg.dst_height);

        push_data.fetch = (in_data.action == ACT_FETCH);
        push_data.err   = (in_data.action == ACT_FETCH) ? fetch_err : load_err;
        push_data.num_x = NUM_W'(in_data.col) * NUM_W'(cfg_reg.src_width);
        push_data.num_y = NUM_W'(in_data.row) * NUM_W'(cfg_reg.src_height);
        push_data.addr  = store_addr(in_data.row, in_data.col);
        push_data.pixel = in_data.pixel_in;
    end

    // Transfer into the queue whenever it has room
    assign in_stall = full;
    assign push     = in_valid && !full;

endmodule

@@ sv/nns_fifo.sv @@
`timescale 1ns / 1ps
module nns_fifo
    import nns_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  op_t     push_data,
    input  logic    pop,
    output op_t     head,
    output logic    empty,
    output logic    full
);

    op_t                  entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W:0]   count_reg;

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Store pushed operations
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head  = entry_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign full  = (count_reg == (FIFO_PTR_W+1)'(FIFO_DEPTH));

endmodule

@@ sv/nns_back.sv @@
`timescale 1ns / 1ps
module nns_back
    import nns_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  op_t         head,
    input  logic        empty,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_data
);

    typedef struct packed {
        logic                 fetch;
        logic                 err;
        logic [NUM_W-1:0]     rem_x;
        logic [NUM_W-1:0]     rem_y;
        logic [Q_W-1:0]       q_x;
        logic [Q_W-1:0]       q_y;
        logic [ADDR_W-1:0]    addr;
        logic [PIX_W-1:0]     pixel;
    } stage_t;

    typedef struct packed {
        logic [NUM_W-1:0]     rem;
        logic [Q_W-1:0]       q;
    } div_t;

    logic [PIX_W-1:0]   mem [MAX_WIDTH * MAX_HEIGHT];
    logic               st_v_reg [Q_W+1];
    stage_t             st_reg [Q_W+1];
    stage_t             st_next [Q_W];
    logic               out_v_reg;
    logic               out_fetch_reg;
    logic               out_err_reg;
    logic [PIX_W-1:0]   rd_reg;
    logic               adv;
    logic [COORD_W-1:0] src_x;
    logic [COORD_W-1:0] src_y;
    logic [ADDR_W-1:0]  rd_addr;

    // One restoring division step for quotient bit k
    function automatic div_t div_step(
        input div_t               a,
        input logic [DIM_W-1:0]   d,
        input int                 k
    );
        div_t               r;
        logic [NUM_W:0]     dv;
        r  = a;
        dv = {(NUM_W+1-DIM_W)'(0), d} << k;
        if ({1'b0, a.rem} >= dv)
        begin
            r.rem  = NUM_W'({1'b0, a.rem} - dv);
            r.q[k] = 1'b1;
        end
        return r;
    endfunction

    // Advance the whole back pipeline unless the result is held
    assign adv = !out_v_reg || !out_stall;
    assign pop = adv && !empty;

    // Compute the next division step of each stage
    always_comb
    begin
        for (int i = 0; i < Q_W; i++)
        begin
            div_t dx;
            div_t dy;
            dx = div_step({st_reg[i].rem_x, st_reg[i].q_x}, cfg.dst_width, Q_W-1-i);
            dy = div_step({st_reg[i].rem_y, st_reg[i].q_y}, cfg.dst_height, Q_W-1-i);
            st_next[i]       = st_reg[i];
            st_next[i].rem_x = dx.rem;
            st_next[i].q_x   = dx.q;
            st_next[i].rem_y = dy.rem;
            st_next[i].q_y   = dy.q;
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= Q_W; i++)
            begin
                st_v_reg[i] <= 1'b0;
            end
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            st_v_reg[0] <= !empty;
            for (int i = 0; i < Q_W; i++)
            begin
                st_v_reg[i+1] <= st_v_reg[i];
            end
            out_v_reg <= st_v_reg[Q_W];
        end
    end

    // Advance stage payloads
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_reg[0].fetch <= head.fetch;
            st_reg[0].err   <= head.err;
            st_reg[0].rem_x <= head.num_x;
            st_reg[0].rem_y <= head.num_y;
            st_reg[0].q_x   <= '0;
            st_reg[0].q_y   <= '0;
            st_reg[0].addr  <= head.addr;
            st_reg[0].pixel <= head.pixel;
            for (int i = 0; i < Q_W; i++)
            begin
                st_reg[i+1] <= st_next[i];
            end
        end
    end

    // Clamp source coordinates and form the store address
    always_comb
    begin
        src_x = ({1'b0, st_reg[Q_W].q_x} >= cfg.src_width) ?
                COORD_W'(cfg.src_width - 1'b1) : st_reg[Q_W].q_x;
        src_y = ({1'b0, st_reg[Q_W].q_y} >= cfg.src_height) ?
                COORD_W'(cfg.src_height - 1'b1) : st_reg[Q_W].q_y;
        rd_addr = store_addr(src_y, src_x);
    end

    // Write loads into the store
    always_ff @(posedge clk)
    begin
        if (adv && st_v_reg[Q_W] && !st_reg[Q_W].fetch && !st_reg[Q_W].err)
        begin
            mem[st_reg[Q_W].addr] <= st_reg[Q_W].pixel;
        end
    end

    // Read the store into the output register
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rd_reg        <= mem[rd_addr];
            out_fetch_reg <= st_reg[Q_W].fetch;
            out_err_reg   <= st_reg[Q_W].err;
        end
    end

    assign out_valid          = out_v_reg;
    assign out_data.pixel_out = (out_fetch_reg && !out_err_reg) ? rd_reg : '0;
    assign out_data.error     = out_err_reg;

endmodule

@@ sv/nns_checker.sv @@
`timescale 1ns / 1ps
`include "nearest_neighbor_scaler_defines.svh"
module nns_checker
    import nns_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_stall,
    input  logic        out_valid,
    input  logic        out_stall,
    input  out_item_t   out_data
);

    // A held result keeps its value
    `NNS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

    // A rejected item never carries a pixel
    `NNS_ASSERT_IMPLY(a_err_zero, clk, rst_n, out_valid && out_data.error, out_data.pixel_out == '0)

    // The input backs up only after the output held a result
    `NNS_ASSERT_IMPLY(a_stall_cause, clk, rst_n, in_stall, $past(out_valid && out_stall))

endmodule

bind nearest_neighbor_scaler nns_checker u_nns_checker (.*);
